[hdl/cbm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, register map and tables for the bank mapper with IRQ timer.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // field widths
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int CYC_W   = 7;
    localparam int BANK_W  = 8;
    localparam int PRESC_W = 8;
    localparam int COUNT_W = 9;

    // default prescaler period in cpu cycles
    localparam int CBM_CYCLES_PER_COUNT = 114;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_CPU   = 2'd2,
        OP_PPU   = 2'd3
    } op_t;

    // register decode
    localparam logic [ADDR_W-1:0] ADDR_MASK  = 16'hF038;
    localparam logic [ADDR_W-1:0] REG_PRG0   = 16'h8000;
    localparam logic [ADDR_W-1:0] REG_PRG1A  = 16'h8008;
    localparam logic [ADDR_W-1:0] REG_PRG1B  = 16'h8010;
    localparam logic [ADDR_W-1:0] REG_PRG2   = 16'h9000;
    localparam logic [ADDR_W-1:0] REG_CHR0   = 16'hA000;
    localparam logic [ADDR_W-1:0] REG_CHR1A  = 16'hA008;
    localparam logic [ADDR_W-1:0] REG_CHR1B  = 16'hA010;
    localparam logic [ADDR_W-1:0] REG_CHR2   = 16'hB000;
    localparam logic [ADDR_W-1:0] REG_CHR3A  = 16'hB008;
    localparam logic [ADDR_W-1:0] REG_CHR3B  = 16'hB010;
    localparam logic [ADDR_W-1:0] REG_CHR4   = 16'hC000;
    localparam logic [ADDR_W-1:0] REG_CHR5A  = 16'hC008;
    localparam logic [ADDR_W-1:0] REG_CHR5B  = 16'hC010;
    localparam logic [ADDR_W-1:0] REG_CHR6   = 16'hD000;
    localparam logic [ADDR_W-1:0] REG_CHR7A  = 16'hD008;
    localparam logic [ADDR_W-1:0] REG_CHR7B  = 16'hD010;
    localparam logic [ADDR_W-1:0] REG_MIRROR = 16'hE000;
    localparam logic [ADDR_W-1:0] REG_RELA   = 16'hE008;
    localparam logic [ADDR_W-1:0] REG_RELB   = 16'hE010;
    localparam logic [ADDR_W-1:0] REG_CTRL   = 16'hF000;
    localparam logic [ADDR_W-1:0] REG_ACKA   = 16'hF008;
    localparam logic [ADDR_W-1:0] REG_ACKB   = 16'hF010;

    // address windows
    localparam logic [ADDR_W-1:0] CPU_FIXED_BASE = 16'hE000;
    localparam logic [ADDR_W-1:0] CPU_ROM_BASE   = 16'h8000;
    localparam logic [ADDR_W-1:0] PPU_NT_BASE    = 16'h2000;
    localparam logic [ADDR_W-1:0] PPU_NT_END     = 16'h3000;
    localparam logic [BANK_W-1:0] LAST_BANK      = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_TOP     = 9'h0FF;

    // timer control from the register decode
    typedef struct packed {
        logic              tick;
        logic              ctrl_wr;
        logic              ack_wr;
        logic              reload_wr;
        logic [DATA_W-1:0] value;
        logic [CYC_W-1:0]  cycles;
    } tmr_ctrl_t;

    // timer status
    typedef struct packed {
        logic pending;
        logic pending_next;
    } tmr_stat_t;

    // nametable page for mirroring mode and quadrant
    function automatic logic mirror_page(input logic [1:0] mode, input logic [1:0] quad);
        logic page;
        case (mode)
            2'd0:    page = quad[0];
            2'd1:    page = quad[1];
            2'd2:    page = 1'b0;
            default: page = 1'b1;
        endcase
        return page;
    endfunction

endpackage
`default_nettype wire

[hdl/cbm_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_if
// Valid/ready channels for mapper operations and their results.
// ----------------------------------------------------------------------------
interface cbm_in_if import cbm_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_value;
    logic [CYC_W-1:0]  cycles;

    modport source (output valid, operation, address, write_value, cycles, input ready);
    modport sink   (input valid, operation, address, write_value, cycles, output ready);
endinterface

interface cbm_out_if import cbm_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BANK_W-1:0] bank_number;
    logic              bank_fixed;
    logic              nametable_page;
    logic              irq_line;

    modport source (output valid, bank_number, bank_fixed, nametable_page, irq_line,
                    input ready);
    modport sink   (input valid, bank_number, bank_fixed, nametable_page, irq_line,
                    output ready);
endinterface
`default_nettype wire

[hdl/cbm_irq_timer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_irq_timer
// Cycle-driven IRQ counter with prescaler, reload, control and acknowledge.
// ----------------------------------------------------------------------------
module cbm_irq_timer import cbm_pkg::*; #(
    parameter int CYCLES_PER_COUNT = CBM_CYCLES_PER_COUNT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire tmr_ctrl_t ctrl,
    output tmr_stat_t      stat
);

    localparam logic [COUNT_W-1:0] PERIOD = COUNT_W'(CYCLES_PER_COUNT);

    logic [DATA_W-1:0]  reload_reg,  reload_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [PRESC_W-1:0] presc_reg,   presc_next;
    logic [1:0]         mode_reg,    mode_next;
    logic               enable_reg,  enable_next;
    logic               pending_reg, pending_next;

    logic [COUNT_W-1:0] sum;
    logic [COUNT_W-1:0] sum_adj;
    logic [COUNT_W-1:0] count_inc;
    logic               wrap;

    // prescaler sum and count increment
    assign sum       = COUNT_W'(presc_reg) + COUNT_W'(ctrl.cycles);
    assign wrap      = (sum >= PERIOD);
    assign sum_adj   = wrap ? (sum - PERIOD) : sum;
    assign count_inc = count_reg + COUNT_W'(1);

    // next state for one operation
    always_comb
    begin
        reload_next  = reload_reg;
        count_next   = count_reg;
        presc_next   = presc_reg;
        mode_next    = mode_reg;
        enable_next  = enable_reg;
        pending_next = pending_reg;
        if (ctrl.reload_wr)
        begin
            reload_next = ctrl.value;
        end
        if (ctrl.ctrl_wr)
        begin
            mode_next    = ctrl.value[1:0];
            enable_next  = ctrl.value[1];
            pending_next = 1'b0;
            if (ctrl.value[1])
            begin
                count_next = COUNT_W'(reload_reg);
                presc_next = '0;
            end
        end
        if (ctrl.ack_wr)
        begin
            enable_next  = mode_reg[0];
            pending_next = 1'b0;
        end
        if (ctrl.tick && enable_reg)
        begin
            presc_next = sum_adj[PRESC_W-1:0];
            if (wrap)
            begin
                if (count_inc >= COUNT_TOP)
                begin
                    count_next   = COUNT_W'(reload_reg);
                    pending_next = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
    end

    // timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg  <= '0;
            count_reg   <= '0;
            presc_reg   <= '0;
            mode_reg    <= '0;
            enable_reg  <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (advance)
        begin
            reload_reg  <= reload_next;
            count_reg   <= count_next;
            presc_reg   <= presc_next;
            mode_reg    <= mode_next;
            enable_reg  <= enable_next;
            pending_reg <= pending_next;
        end
    end

    assign stat.pending      = pending_reg;
    assign stat.pending_next = pending_next;

endmodule
`default_nettype wire

[hdl/cartridge_bank_mapper_with_irq_timer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// An input transfer is held in the input register, and its result in the result register.
// Throughput: one operation per cycle unless out_ch.ready stalls; result and input registers form a
// two-entry pipeline, so a new operation is taken while a result waits to be collected.
// Reset (rst_n low, asynchronous) clears all bank, mirroring and timer state to zero
// and empties the pipeline.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_timer_unit
// Program/character bank mapper with mirroring control and a cycle-driven IRQ timer.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq_timer_unit import cbm_pkg::*; #(
    parameter int CYCLES_PER_COUNT = CBM_CYCLES_PER_COUNT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cbm_in_if.sink    in_ch,
    cbm_out_if.source out_ch
);

    // input stage
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [DATA_W-1:0] s1_value_reg;
    logic [CYC_W-1:0]  s1_cycles_reg;

    // result stage
    logic              out_valid_reg;
    logic [BANK_W-1:0] bank_reg,  bank_next;
    logic              fixed_reg, fixed_next;
    logic              page_reg,  page_next;
    logic              irq_reg;

    // mapper state
    logic [BANK_W-1:0] prg_reg [3];
    logic [BANK_W-1:0] chr_reg [8];
    logic [1:0]        mirror_reg;

    logic              advance;
    logic              in_xfer;
    logic [ADDR_W-1:0] reg_sel;
    tmr_ctrl_t         tmr_ctrl;
    tmr_stat_t         tmr_stat;

    // pipeline flow
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign reg_sel     = s1_addr_reg & ADDR_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg     <= op_t'(in_ch.operation);
            s1_addr_reg   <= in_ch.address;
            s1_value_reg  <= in_ch.write_value;
            s1_cycles_reg <= in_ch.cycles;
        end
    end

    // timer decode
    always_comb
    begin
        tmr_ctrl.tick      = (s1_op_reg == OP_TICK);
        tmr_ctrl.ctrl_wr   = (s1_op_reg == OP_WRITE) && (reg_sel == REG_CTRL);
        tmr_ctrl.ack_wr    = (s1_op_reg == OP_WRITE) &&
                             ((reg_sel == REG_ACKA) || (reg_sel == REG_ACKB));
        tmr_ctrl.reload_wr = (s1_op_reg == OP_WRITE) &&
                             ((reg_sel == REG_RELA) || (reg_sel == REG_RELB));
        tmr_ctrl.value     = s1_value_reg;
        tmr_ctrl.cycles    = s1_cycles_reg;
    end

    cbm_irq_timer #(
        .CYCLES_PER_COUNT (CYCLES_PER_COUNT)
    ) u_timer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ctrl    (tmr_ctrl),
        .stat    (tmr_stat)
    );

    // bank and mirroring registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prg_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                chr_reg[i] <= '0;
            end
            mirror_reg <= '0;
        end
        else if (advance && (s1_op_reg == OP_WRITE))
        begin
            case (reg_sel)
                REG_PRG0:             prg_reg[0] <= s1_value_reg;
                REG_PRG1A, REG_PRG1B: prg_reg[1] <= s1_value_reg;
                REG_PRG2:             prg_reg[2] <= s1_value_reg;
                REG_CHR0:             chr_reg[0] <= s1_value_reg;
                REG_CHR1A, REG_CHR1B: chr_reg[1] <= s1_value_reg;
                REG_CHR2:             chr_reg[2] <= s1_value_reg;
                REG_CHR3A, REG_CHR3B: chr_reg[3] <= s1_value_reg;
                REG_CHR4:             chr_reg[4] <= s1_value_reg;
                REG_CHR5A, REG_CHR5B: chr_reg[5] <= s1_value_reg;
                REG_CHR6:             chr_reg[6] <= s1_value_reg;
                REG_CHR7A, REG_CHR7B: chr_reg[7] <= s1_value_reg;
                REG_MIRROR:           mirror_reg <= s1_value_reg[1:0];
                default:              ;
            endcase
        end
    end

    // address translation
    always_comb
    begin
        bank_next  = '0;
        fixed_next = 1'b0;
        page_next  = 1'b0;
        case (s1_op_reg)
            OP_CPU:
            begin
                if (s1_addr_reg >= CPU_FIXED_BASE)
                begin
                    bank_next  = LAST_BANK;
                    fixed_next = 1'b1;
                end
                else if (s1_addr_reg >= CPU_ROM_BASE)
                begin
                    bank_next = prg_reg[s1_addr_reg[14:13]];
                end
            end
            OP_PPU:
            begin
                if (s1_addr_reg < PPU_NT_BASE)
                begin
                    bank_next = chr_reg[s1_addr_reg[12:10]];
                end
                else if (s1_addr_reg < PPU_NT_END)
                begin
                    page_next = mirror_page(mirror_reg, s1_addr_reg[11:10]);
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bank_reg  <= bank_next;
            fixed_reg <= fixed_next;
            page_reg  <= page_next;
            irq_reg   <= tmr_stat.pending_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.bank_number    = bank_reg;
    assign out_ch.bank_fixed     = fixed_reg;
    assign out_ch.nametable_page = page_reg;
    assign out_ch.irq_line       = irq_reg;

    // checks
    a_fixed_last_bank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fixed_reg |-> bank_reg == LAST_BANK && !page_reg)
        else $error("fixed slot result without last bank");

    a_irq_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tmr_stat.pending) |-> $past(advance && (s1_op_reg == OP_TICK)))
        else $error("irq raised by something other than a tick");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while pipeline is full");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after stage advance");

endmodule
`default_nettype wire

[verif/cartridge_bank_mapper_with_irq_timer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_timer_unit_tb
// Drives register writes, timer ticks and cpu/ppu address translations into the
// mapper and checks every result transfer, field by field, against an in-bench
// model of the bank registers, mirroring and irq timer, under varied back-pressure.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq_timer_unit_tb import cbm_pkg::*; ;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_ITEMS_PER_PHASE = 100;

    // irq control register bits
    localparam int CTRL_ENABLE_BIT = 1;
    localparam int CTRL_REARM_BIT  = 0;

    typedef enum logic [1:0] {
        MIR_VERTICAL   = 2'd0,
        MIR_HORIZONTAL = 2'd1,
        MIR_SINGLE0    = 2'd2,
        MIR_SINGLE1    = 2'd3
    } mirror_t;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic              fixed;
        logic              page;
        logic              irq;
    } mapper_result_t;

    // ------------------------------------------------------------------------
    // mapper model and result checker
    // ------------------------------------------------------------------------
    class mapper_tracker;
        logic [BANK_W-1:0]  prg_bank [3];
        logic [BANK_W-1:0]  chr_bank [8];
        mirror_t            mirror;
        logic [DATA_W-1:0]  reload;
        logic [COUNT_W-1:0] count;
        logic [PRESC_W-1:0] presc;
        logic [1:0]         irq_mode;
        logic               irq_en;
        logic               irq_pend;
        mapper_result_t     awaited_results [$];
        int                 errors;

        function new();
            foreach (prg_bank[i]) prg_bank[i] = '0;
            foreach (chr_bank[i]) chr_bank[i] = '0;
            mirror   = MIR_VERTICAL;
            reload   = '0;
            count    = '0;
            presc    = '0;
            irq_mode = '0;
            irq_en   = 1'b0;
            irq_pend = 1'b0;
            errors   = 0;
        endfunction

        // update state for one accepted operation and queue its result
        function void note_transfer(op_t op, logic [ADDR_W-1:0] addr,
                                    logic [DATA_W-1:0] val, logic [CYC_W-1:0] cyc);
            mapper_result_t r;
            logic [8:0]     sum;
            r = '0;
            case (op)
                OP_WRITE:
                begin
                    case (addr & ADDR_MASK)
                        REG_PRG0:              prg_bank[0] = val;
                        REG_PRG1A, REG_PRG1B:  prg_bank[1] = val;
                        REG_PRG2:              prg_bank[2] = val;
                        REG_CHR0:              chr_bank[0] = val;
                        REG_CHR1A, REG_CHR1B:  chr_bank[1] = val;
                        REG_CHR2:              chr_bank[2] = val;
                        REG_CHR3A, REG_CHR3B:  chr_bank[3] = val;
                        REG_CHR4:              chr_bank[4] = val;
                        REG_CHR5A, REG_CHR5B:  chr_bank[5] = val;
                        REG_CHR6:              chr_bank[6] = val;
                        REG_CHR7A, REG_CHR7B:  chr_bank[7] = val;
                        REG_MIRROR:            mirror = mirror_t'(val[1:0]);
                        REG_RELA, REG_RELB:    reload = val;
                        REG_CTRL:
                        begin
                            irq_mode = val[1:0];
                            if (val[CTRL_ENABLE_BIT])
                            begin
                                count = {1'b0, reload};
                                presc = '0;
                            end
                            irq_en   = val[CTRL_ENABLE_BIT];
                            irq_pend = 1'b0;
                        end
                        REG_ACKA, REG_ACKB:
                        begin
                            irq_en   = irq_mode[CTRL_REARM_BIT];
                            irq_pend = 1'b0;
                        end
                        default: ;
                    endcase
                end
                OP_TICK:
                begin
                    // one count step at most per tick
                    if (irq_en)
                    begin
                        sum = {1'b0, presc} + 9'(cyc);
                        if (sum >= 9'(CBM_CYCLES_PER_COUNT))
                        begin
                            sum   = sum - 9'(CBM_CYCLES_PER_COUNT);
                            count = count + 1'b1;
                            if (count >= COUNT_TOP)
                            begin
                                count    = {1'b0, reload};
                                irq_pend = 1'b1;
                            end
                        end
                        presc = sum[PRESC_W-1:0];
                    end
                end
                OP_CPU:
                begin
                    if (addr >= CPU_FIXED_BASE)
                    begin
                        r.bank  = LAST_BANK;
                        r.fixed = 1'b1;
                    end
                    else if (addr >= CPU_ROM_BASE)
                        r.bank = prg_bank[addr[14:13]];
                end
                default:
                begin
                    if (addr < PPU_NT_BASE)
                        r.bank = chr_bank[addr[12:10]];
                    else if (addr < PPU_NT_END)
                    begin
                        case (mirror)
                            MIR_VERTICAL:   r.page = addr[10];
                            MIR_HORIZONTAL: r.page = addr[11];
                            MIR_SINGLE0:    r.page = 1'b0;
                            default:        r.page = 1'b1;
                        endcase
                    end
                end
            endcase
            r.irq = irq_pend;
            awaited_results.push_back(r);
        endfunction

        // compare one result transfer with the oldest awaited result
        function void check_result(mapper_result_t got);
            mapper_result_t exp;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer %h", $time, got);
                errors++;
                return;
            end
            exp = awaited_results.pop_front();
            if (got.bank != exp.bank)
            begin
                $display("%0t: bank_number expected %0h got %0h", $time, exp.bank, got.bank);
                errors++;
            end
            if (got.fixed != exp.fixed)
            begin
                $display("%0t: bank_fixed expected %0b got %0b", $time, exp.fixed, got.fixed);
                errors++;
            end
            if (got.page != exp.page)
            begin
                $display("%0t: nametable_page expected %0b got %0b", $time, exp.page, got.page);
                errors++;
            end
            if (got.irq != exp.irq)
            begin
                $display("%0t: irq_line expected %0b got %0b", $time, exp.irq, got.irq);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   cycle_count;

    mapper_tracker tracker;

    // decoded register bases; the timer registers sit at the end
    logic [ADDR_W-1:0] reg_map [0:21] = '{
        REG_PRG0, REG_PRG1A, REG_PRG1B, REG_PRG2,
        REG_CHR0, REG_CHR1A, REG_CHR1B, REG_CHR2, REG_CHR3A, REG_CHR3B,
        REG_CHR4, REG_CHR5A, REG_CHR5B, REG_CHR6, REG_CHR7A, REG_CHR7B,
        REG_MIRROR, REG_RELA, REG_RELB, REG_CTRL, REG_ACKA, REG_ACKB
    };

    cbm_in_if  in_ch ();
    cbm_out_if out_ch ();

    cartridge_bank_mapper_with_irq_timer_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // result side: sample on rising edge, change ready on falling edge
    initial
    begin
        out_ch.ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                tracker.check_result({out_ch.bank_number, out_ch.bank_fixed,
                                      out_ch.nametable_page, out_ch.irq_line});
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // send one operation, with random idle cycles ahead of it
    task automatic push_item(input op_t op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] val, input logic [CYC_W-1:0] cyc);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.operation   = op;
        in_ch.address     = addr;
        in_ch.write_value = val;
        in_ch.cycles      = cyc;
        do
            @(posedge clk);
        while (!in_ch.ready);
        tracker.note_transfer(op, addr, val, cyc);
        @(negedge clk);
    endtask

    // random operation, biased towards timer programming and long ticks
    task automatic push_random_item();
        int                pick;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;
        logic [DATA_W-1:0] val;
        logic [CYC_W-1:0]  cyc;
        op_t               op;
        pick = $urandom_range(99);
        addr = ADDR_W'($urandom);
        val  = DATA_W'($urandom);
        cyc  = CYC_W'($urandom_range(CBM_CYCLES_PER_COUNT));
        if (pick < 32)
        begin
            op = OP_WRITE;
            if ($urandom_range(99) < 88)
            begin
                if ($urandom_range(99) < 40)
                    base = reg_map[$urandom_range(21, 17)];
                else
                    base = reg_map[$urandom_range(21)];
                addr = base | (addr & ~ADDR_MASK);
                // reload values near the top make the irq fire within a few ticks
                if ((base == REG_RELA || base == REG_RELB) && $urandom_range(99) < 70)
                    val = DATA_W'($urandom_range(8'hFF, 8'hF0));
                else if (base == REG_CTRL && $urandom_range(99) < 75)
                    val[CTRL_ENABLE_BIT] = 1'b1;
            end
        end
        else if (pick < 67)
        begin
            op = OP_TICK;
            if ($urandom_range(99) < 75)
                cyc = CYC_W'($urandom_range(CBM_CYCLES_PER_COUNT, 60));
        end
        else if (pick < 83)
            op = OP_CPU;
        else
        begin
            op = OP_PPU;
            if ($urandom_range(99) < 60)
                addr = ADDR_W'($urandom_range(16'h2FFF));
        end
        push_item(op, addr, val, cyc);
    endtask

    // main sequence
    initial
    begin
        int send_idle [4];
        int recv_stall [4];
        send_idle  = '{0, 63, 0, 23};
        recv_stall = '{0, 0, 63, 23};
        tracker = new();
        idle_pct  = 0;
        stall_pct = 0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_WRITE;
        in_ch.address     = '0;
        in_ch.write_value = '0;
        in_ch.cycles      = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // bank registers through base and alias addresses, extreme values
        push_item(OP_WRITE, REG_PRG0, 8'hFF, '0);
        push_item(OP_WRITE, REG_PRG1A, 8'h01, '0);
        push_item(OP_WRITE, REG_PRG2 | ~ADDR_MASK, 8'h80, '0);
        // sound port writes change nothing
        push_item(OP_WRITE, 16'h9010, 8'h55, '0);
        push_item(OP_WRITE, 16'h9030, 8'hAA, '0);
        push_item(OP_WRITE, REG_CHR1B, 8'h7F, '0);
        push_item(OP_WRITE, REG_CHR7A, 8'hFE, '0);
        push_item(OP_WRITE, REG_MIRROR, 8'hFF, '0);
        // tick while the timer is still disabled
        push_item(OP_TICK, '0, '0, 7'd114);
        // reload at the top, enable, then a count step that raises the irq
        push_item(OP_WRITE, REG_RELB, 8'hFF, '0);
        push_item(OP_WRITE, REG_CTRL, 8'h02, '0);
        push_item(OP_TICK, '0, '0, 7'd0);
        push_item(OP_TICK, '0, '0, 7'd113);
        push_item(OP_TICK, '0, '0, 7'd114);
        // cpu windows: below rom, switchable slots, fixed last slot
        push_item(OP_CPU, 16'h7FFF, '0, '0);
        push_item(OP_CPU, 16'h8000, '0, '0);
        push_item(OP_CPU, 16'hDFFF, '0, '0);
        push_item(OP_CPU, 16'hE000, '0, '0);
        push_item(OP_CPU, 16'hFFFF, '0, '0);
        // ppu windows: pattern tables, nametables, above 3000
        push_item(OP_PPU, 16'h0000, '0, '0);
        push_item(OP_PPU, 16'h1FFF, '0, '0);
        push_item(OP_PPU, 16'h2000, '0, '0);
        push_item(OP_PPU, 16'h2FFF, '0, '0);
        push_item(OP_PPU, 16'h3000, '0, '0);
        // acknowledge with rearm clear disables the timer
        push_item(OP_WRITE, REG_ACKA, 8'h00, '0);

        // random traffic under each back-pressure pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = send_idle[ph];
            stall_pct = recv_stall[ph];
            repeat (RANDOM_ITEMS_PER_PHASE) push_random_item();
        end
        in_ch.valid = 1'b0;
        stall_pct   = 0;

        // drain and let the pipeline settle
        while (tracker.outstanding() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[cartridge_bank_mapper_with_irq_timer_unit.f]
hdl/cbm_pkg.sv
hdl/cbm_if.sv
hdl/cbm_irq_timer.sv
hdl/cartridge_bank_mapper_with_irq_timer_unit.sv
verif/cartridge_bank_mapper_with_irq_timer_unit_tb.sv
